/* design/yrp_pkg.sv */
// Package for the Y-rotation perspective projection block.
// Request/result types, register indexes, widths, CORDIC table and output saturation.
// No dependencies.
`default_nettype none
package yrp_pkg;

	localparam int COORD_WIDTH  = 16;
	localparam int FRAC_BITS    = 8;
	localparam int ANGLE_WIDTH  = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int CORDIC_ITERS = 16;
	localparam int CORDIC_W     = 20;
	localparam int ANG_ZW       = 33;
	localparam int DIV_BITS     = 17;
	localparam int NUM_W        = 40;
	localparam int LATENCY      = 9 + CORDIC_ITERS + DIV_BITS - 1;

	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 20'sd39796;

	localparam logic [CFG_IDX_W-1:0] REG_ROTATION_STEP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_DISTANCE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROJECTION_SCALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT    = 3'd4;

	localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = 16'sh7fff;
	localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = 16'sh8000;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] vertex_x;
		logic signed [COORD_WIDTH-1:0] vertex_y;
		logic signed [COORD_WIDTH-1:0] vertex_z;
		logic [15:0]                   frame_index;
	} vertex_req_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] screen_x;
		logic signed [COORD_WIDTH-1:0] screen_y;
		logic                          invalid;
	} proj_res_t;

	// arctangent per iteration, units of 2^-32 turn
	function automatic logic signed [ANG_ZW-1:0] atan_lut(input int idx);
		logic signed [ANG_ZW-1:0] v;
		case (idx)
			0:  v = 33'sd536870912;
			1:  v = 33'sd316933406;
			2:  v = 33'sd167458907;
			3:  v = 33'sd85004756;
			4:  v = 33'sd42667331;
			5:  v = 33'sd21354465;
			6:  v = 33'sd10680862;
			7:  v = 33'sd5340245;
			8:  v = 33'sd2670163;
			9:  v = 33'sd1335087;
			10: v = 33'sd667544;
			11: v = 33'sd333772;
			12: v = 33'sd166886;
			13: v = 33'sd83443;
			14: v = 33'sd41722;
			15: v = 33'sd20861;
			default: v = '0;
		endcase
		return v;
	endfunction

	// {saturated, value} from quotient magnitude, sign and overflow
	function automatic logic [COORD_WIDTH:0] sat_quot(input logic neg, input logic ovf,
			input logic [DIV_BITS-1:0] q);
		logic [DIV_BITS-1:0] nq;
		nq = -q;
		if (neg) begin
			if (ovf || q > 17'd32768)
				return {1'b1, SAT_MIN};
			return {1'b0, nq[COORD_WIDTH-1:0]};
		end
		if (ovf || q > 17'd32767)
			return {1'b1, SAT_MAX};
		return {1'b0, q[COORD_WIDTH-1:0]};
	endfunction

endpackage
`default_nettype wire

/* design/y_rotate_perspective_project.sv */
// Y-axis rotation and perspective projection, fully pipelined.
// Uses yrp_pkg for types, register indexes, CORDIC table and saturation.
//
// One vertex per clock, results in order. The pipeline holds the 16-stage CORDIC
// for sin/cos and the 17-stage restoring divider for the perspective divide.
// busy is always low and done pulses one cycle per result; the receiver must
// take it in that cycle. Registers are written through cfg_we/cfg_index/cfg_data;
// the user must do so only while no request is in flight, the block does not enforce it.
`default_nettype none
module y_rotate_perspective_project import yrp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire vertex_req_t           request,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       done,
	output proj_res_t                  result
);

	logic [15:0] rotation_step_q;
	logic [14:0] view_distance_q;
	logic [15:0] projection_scale_q;
	logic [11:0] screen_width_q;
	logic [11:0] screen_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_step_q    <= 16'd1024;
			view_distance_q    <= 15'd768;
			projection_scale_q <= 16'd32;
			screen_width_q     <= 12'd80;
			screen_height_q    <= 12'd40;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROTATION_STEP:    rotation_step_q    <= cfg_data[15:0];
				REG_VIEW_DISTANCE:    view_distance_q    <= cfg_data[14:0];
				REG_PROJECTION_SCALE: projection_scale_q <= cfg_data[15:0];
				REG_SCREEN_WIDTH:     screen_width_q     <= cfg_data[11:0];
				REG_SCREEN_HEIGHT:    screen_height_q    <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic signed [16:0] scale_sv;
	logic signed [11:0] cx_sv, cy_sv;
	assign scale_sv = $signed({1'b0, projection_scale_q});
	assign cx_sv    = $signed({1'b0, screen_width_q[11:1]});
	assign cy_sv    = $signed({1'b0, screen_height_q[11:1]});

	// s1: angle = frame * step, wrapped
	logic [31:0] ang_prod;
	assign ang_prod = request.frame_index * rotation_step_q;

	logic                          v_s1;
	logic [ANGLE_WIDTH-1:0]        angle_s1;
	logic signed [COORD_WIDTH-1:0] vx_s1, vy_s1, vz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start & ~busy;
	end

	always_ff @(posedge clk) begin
		angle_s1 <= ang_prod[ANGLE_WIDTH-1:0];
		vx_s1    <= request.vertex_x;
		vy_s1    <= request.vertex_y;
		vz_s1    <= request.vertex_z;
	end

	// CORDIC: entry 0 is the initial vector, entry i+1 follows iteration i
	logic                          cor_v_s    [0:CORDIC_ITERS];
	logic                          cor_flip_s [0:CORDIC_ITERS];
	logic signed [CORDIC_W-1:0]    cor_x_s    [0:CORDIC_ITERS];
	logic signed [CORDIC_W-1:0]    cor_y_s    [0:CORDIC_ITERS];
	logic signed [ANG_ZW-1:0]      cor_z_s    [0:CORDIC_ITERS];
	logic signed [COORD_WIDTH-1:0] cor_vx_s   [0:CORDIC_ITERS];
	logic signed [COORD_WIDTH-1:0] cor_vy_s   [0:CORDIC_ITERS];
	logic signed [COORD_WIDTH-1:0] cor_vz_s   [0:CORDIC_ITERS];

	logic flip_in, ztop;
	assign flip_in = angle_s1[15] ^ angle_s1[14];
	assign ztop    = angle_s1[15] ^ flip_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cor_v_s[0] <= 1'b0;
		else         cor_v_s[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		cor_flip_s[0] <= flip_in;
		cor_x_s[0]    <= CORDIC_GAIN;
		cor_y_s[0]    <= '0;
		cor_z_s[0]    <= $signed({ztop, ztop, angle_s1[14:0], 16'b0});
		cor_vx_s[0]   <= vx_s1;
		cor_vy_s[0]   <= vy_s1;
		cor_vz_s[0]   <= vz_s1;
	end

	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cor_v_s[i+1] <= 1'b0;
			else         cor_v_s[i+1] <= cor_v_s[i];
		end

		always_ff @(posedge clk) begin
			if (!cor_z_s[i][ANG_ZW-1]) begin
				cor_x_s[i+1] <= cor_x_s[i] - (cor_y_s[i] >>> i);
				cor_y_s[i+1] <= cor_y_s[i] + (cor_x_s[i] >>> i);
				cor_z_s[i+1] <= cor_z_s[i] - atan_lut(i);
			end else begin
				cor_x_s[i+1] <= cor_x_s[i] + (cor_y_s[i] >>> i);
				cor_y_s[i+1] <= cor_y_s[i] - (cor_x_s[i] >>> i);
				cor_z_s[i+1] <= cor_z_s[i] + atan_lut(i);
			end
			cor_flip_s[i+1] <= cor_flip_s[i];
			cor_vx_s[i+1]   <= cor_vx_s[i];
			cor_vy_s[i+1]   <= cor_vy_s[i];
			cor_vz_s[i+1]   <= cor_vz_s[i];
		end
	end

	// s3: quadrant fix
	logic                          v_s3;
	logic signed [CORDIC_W-1:0]    cos_s3, sin_s3;
	logic signed [COORD_WIDTH-1:0] vx_s3, vy_s3, vz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= cor_v_s[CORDIC_ITERS];
	end

	always_ff @(posedge clk) begin
		cos_s3 <= cor_flip_s[CORDIC_ITERS] ? -cor_x_s[CORDIC_ITERS] : cor_x_s[CORDIC_ITERS];
		sin_s3 <= cor_flip_s[CORDIC_ITERS] ? -cor_y_s[CORDIC_ITERS] : cor_y_s[CORDIC_ITERS];
		vx_s3  <= cor_vx_s[CORDIC_ITERS];
		vy_s3  <= cor_vy_s[CORDIC_ITERS];
		vz_s3  <= cor_vz_s[CORDIC_ITERS];
	end

	// s4: rotation products
	logic                          v_s4;
	logic signed [35:0]            pxc_s4, pzs_s4, pzc_s4, pxs_s4;
	logic signed [COORD_WIDTH-1:0] vy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		pxc_s4 <= vx_s3 * cos_s3;
		pzs_s4 <= vz_s3 * sin_s3;
		pzc_s4 <= vz_s3 * cos_s3;
		pxs_s4 <= vx_s3 * sin_s3;
		vy_s4  <= vy_s3;
	end

	// s5: rotated x, depth
	logic signed [36:0] sum_x, sum_z, sh_x, sh_z;
	logic signed [20:0] rz_n;
	logic signed [21:0] depth_n;
	assign sum_x   = 37'(pxc_s4) + 37'(pzs_s4);
	assign sum_z   = 37'(pzc_s4) - 37'(pxs_s4);
	assign sh_x    = sum_x >>> 16;
	assign sh_z    = sum_z >>> 16;
	assign rz_n    = sh_z[20:0];
	assign depth_n = 22'(rz_n) + $signed({7'b0, view_distance_q});

	logic                          v_s5;
	logic signed [20:0]            rx_s5;
	logic signed [21:0]            depth_s5;
	logic signed [COORD_WIDTH-1:0] vy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else         v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		rx_s5    <= sh_x[20:0];
		depth_s5 <= depth_n;
		vy_s5    <= vy_s4;
	end

	// s6: numerator products
	logic               v_s6, pos_s6;
	logic signed [37:0] prx_s6;
	logic signed [33:0] pcx_s6, pcy_s6;
	logic signed [32:0] pvy_s6;
	logic [20:0]        den_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else         v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		prx_s6 <= rx_s5 * scale_sv;
		pcx_s6 <= cx_sv * depth_s5;
		pcy_s6 <= cy_sv * depth_s5;
		pvy_s6 <= vy_s5 * scale_sv;
		pos_s6 <= (depth_s5 > 22'sd0);
		den_s6 <= depth_s5[20:0];
	end

	// s7: numerators, sign, magnitude, overflow
	logic signed [NUM_W-1:0] num_x, num_y;
	logic [NUM_W-1:0]        abs_x, abs_y, den_lim;
	assign num_x   = NUM_W'(prx_s6) + NUM_W'(pcx_s6);
	assign num_y   = NUM_W'(pcy_s6) - NUM_W'(pvy_s6);
	assign abs_x   = num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
	assign abs_y   = num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);
	assign den_lim = NUM_W'(den_s6) << DIV_BITS;

	// divider: entry 0 from s7, entry k+1 has quotient bit DIV_BITS-1-k
	logic                dv_v_s   [0:DIV_BITS];
	logic                dv_pos_s [0:DIV_BITS];
	logic                dv_nx_s  [0:DIV_BITS];
	logic                dv_ny_s  [0:DIV_BITS];
	logic                dv_ox_s  [0:DIV_BITS];
	logic                dv_oy_s  [0:DIV_BITS];
	logic [20:0]         dv_den_s [0:DIV_BITS];
	logic [NUM_W-1:0]    dv_rx_s  [0:DIV_BITS];
	logic [NUM_W-1:0]    dv_ry_s  [0:DIV_BITS];
	logic [DIV_BITS-1:0] dv_qx_s  [0:DIV_BITS];
	logic [DIV_BITS-1:0] dv_qy_s  [0:DIV_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else         dv_v_s[0] <= v_s6;
	end

	always_ff @(posedge clk) begin
		dv_pos_s[0] <= pos_s6;
		dv_nx_s[0]  <= num_x[NUM_W-1];
		dv_ny_s[0]  <= num_y[NUM_W-1];
		dv_ox_s[0]  <= (abs_x >= den_lim);
		dv_oy_s[0]  <= (abs_y >= den_lim);
		dv_den_s[0] <= den_s6;
		dv_rx_s[0]  <= abs_x;
		dv_ry_s[0]  <= abs_y;
		dv_qx_s[0]  <= '0;
		dv_qy_s[0]  <= '0;
	end

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
		logic [NUM_W-1:0] dsh;
		assign dsh = NUM_W'(dv_den_s[k]) << (DIV_BITS - 1 - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[k+1] <= 1'b0;
			else         dv_v_s[k+1] <= dv_v_s[k];
		end

		always_ff @(posedge clk) begin
			dv_pos_s[k+1] <= dv_pos_s[k];
			dv_nx_s[k+1]  <= dv_nx_s[k];
			dv_ny_s[k+1]  <= dv_ny_s[k];
			dv_ox_s[k+1]  <= dv_ox_s[k];
			dv_oy_s[k+1]  <= dv_oy_s[k];
			dv_den_s[k+1] <= dv_den_s[k];
			if (dv_rx_s[k] >= dsh) begin
				dv_rx_s[k+1] <= dv_rx_s[k] - dsh;
				dv_qx_s[k+1] <= dv_qx_s[k] | (DIV_BITS'(1) << (DIV_BITS - 1 - k));
			end else begin
				dv_rx_s[k+1] <= dv_rx_s[k];
				dv_qx_s[k+1] <= dv_qx_s[k];
			end
			if (dv_ry_s[k] >= dsh) begin
				dv_ry_s[k+1] <= dv_ry_s[k] - dsh;
				dv_qy_s[k+1] <= dv_qy_s[k] | (DIV_BITS'(1) << (DIV_BITS - 1 - k));
			end else begin
				dv_ry_s[k+1] <= dv_ry_s[k];
				dv_qy_s[k+1] <= dv_qy_s[k];
			end
		end
	end

	// output: sign, saturate, depth check
	logic [COORD_WIDTH:0] fin_x, fin_y;
	assign fin_x = sat_quot(dv_nx_s[DIV_BITS], dv_ox_s[DIV_BITS], dv_qx_s[DIV_BITS]);
	assign fin_y = sat_quot(dv_ny_s[DIV_BITS], dv_oy_s[DIV_BITS], dv_qy_s[DIV_BITS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= dv_v_s[DIV_BITS];
	end

	always_ff @(posedge clk) begin
		if (dv_pos_s[DIV_BITS]) begin
			result.screen_x <= $signed(fin_x[COORD_WIDTH-1:0]);
			result.screen_y <= $signed(fin_y[COORD_WIDTH-1:0]);
			result.invalid  <= fin_x[COORD_WIDTH] | fin_y[COORD_WIDTH];
		end else begin
			result.screen_x <= '0;
			result.screen_y <= '0;
			result.invalid  <= 1'b1;
		end
	end

endmodule
`default_nettype wire

/* design/yrp_checker.sv */
// Port-level checks for y_rotate_perspective_project, bound to the top level.
// Uses yrp_pkg for latency and saturation limits.
`default_nettype none
module yrp_checker import yrp_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire proj_res_t   result
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && arst_n, LATENCY))
		else $error("result without matching request");

	a_invalid_form: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.invalid) |->
			((result.screen_x == 16'sd0 && result.screen_y == 16'sd0) ||
			 result.screen_x == SAT_MAX || result.screen_x == SAT_MIN ||
			 result.screen_y == SAT_MAX || result.screen_y == SAT_MIN))
		else $error("invalid result neither zeroed nor saturated");

endmodule

bind y_rotate_perspective_project yrp_checker u_yrp_checker (.*);
`default_nettype wire

/* verif/y_rotate_perspective_project_test.sv */
// Testbench for y_rotate_perspective_project: directed and random vertices through the
// command port, checked against an in-bench fixed-point projection predictor.
// Depends on yrp_pkg and the design top level.
`timescale 1ns / 1ps

class proj_scoreboard;
	yrp_pkg::proj_res_t pending[$];
	int errors;
	int checked;

	function void note_request(yrp_pkg::proj_res_t exp_res);
		pending.push_back(exp_res);
	endfunction

	function void check_result(yrp_pkg::proj_res_t got);
		yrp_pkg::proj_res_t exp_res;
		if (pending.size() == 0) begin
			$error("result with nothing pending: %h", got);
			errors++;
			return;
		end
		exp_res = pending.pop_front();
		checked++;
		if (got.screen_x !== exp_res.screen_x) begin
			$error("screen_x expected %0d actual %0d", exp_res.screen_x, got.screen_x);
			errors++;
		end
		if (got.screen_y !== exp_res.screen_y) begin
			$error("screen_y expected %0d actual %0d", exp_res.screen_y, got.screen_y);
			errors++;
		end
		if (got.invalid !== exp_res.invalid) begin
			$error("invalid expected %0d actual %0d", exp_res.invalid, got.invalid);
			errors++;
		end
	endfunction
endclass

module y_rotate_perspective_project_test;
	import yrp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	vertex_req_t request = '0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic done;
	proj_res_t result;

	longint unsigned rot_step, view_dist, proj_scale, scr_w, scr_h;
	proj_scoreboard sb;
	int cycles;
	int sent;

	y_rotate_perspective_project DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .result(result)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && done)
			sb.check_result(result);

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint trunc_div(longint n, longint d);
		longint q;
		q = (n < 0 ? -n : n) / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic void saturate(inout longint v, inout logic bad);
		if (v > 32767) begin
			v = 32767;
			bad = 1;
		end else if (v < -32768) begin
			v = -32768;
			bad = 1;
		end
	endfunction

	function automatic proj_res_t project(vertex_req_t req);
		longint atan_k[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861};
		logic [31:0] a32;
		logic flip;
		longint x, y, z, nx, c, s, vx, vy, vz, rx, rz, depth, sx, sy;
		logic bad;
		proj_res_t r;
		a32 = {16'(longint'(req.frame_index) * rot_step), 16'h0};
		flip = (a32[31:30] == 2'd1) || (a32[31:30] == 2'd2);
		if (flip)
			a32 = a32 + 32'h8000_0000;
		z = longint'($signed(a32));
		x = 39796;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z = z - atan_k[i];
			end else begin
				nx = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z = z + atan_k[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
		vx = req.vertex_x;
		vy = req.vertex_y;
		vz = req.vertex_z;
		rx = floor_shift(vx * c + vz * s, 16);
		rz = floor_shift(vz * c - vx * s, 16);
		depth = rz + longint'(view_dist);
		bad = 0;
		sx = 0;
		sy = 0;
		if (depth <= 0)
			bad = 1;
		else begin
			sx = trunc_div(rx * longint'(proj_scale) + longint'(scr_w / 2) * depth, depth);
			sy = trunc_div(longint'(scr_h / 2) * depth - vy * longint'(proj_scale), depth);
			saturate(sx, bad);
			saturate(sy, bad);
		end
		r.screen_x = 16'(sx);
		r.screen_y = 16'(sy);
		r.invalid = bad;
		return r;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= 16'(val);
		case (idx)
			REG_ROTATION_STEP:    rot_step = val & 16'hffff;
			REG_VIEW_DISTANCE:    view_dist = val & 15'h7fff;
			REG_PROJECTION_SCALE: proj_scale = val & 16'hffff;
			REG_SCREEN_WIDTH:     scr_w = val & 12'hfff;
			REG_SCREEN_HEIGHT:    scr_h = val & 12'hfff;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_config(longint unsigned rs, vd, ps, w, h);
		write_reg(REG_ROTATION_STEP, rs);
		write_reg(REG_VIEW_DISTANCE, vd);
		write_reg(REG_PROJECTION_SCALE, ps);
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// holds start high across back-to-back requests; lowers it only for a gap
	task automatic send(vertex_req_t req, bit gaps);
		if (gaps && $urandom_range(0, 7) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		start <= 1;
		request <= req;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(project(req));
		sent++;
	endtask

	task automatic end_burst();
		start <= 0;
	endtask

	function automatic vertex_req_t rand_vertex(bit narrow);
		vertex_req_t v;
		v = {$urandom, $urandom};
		v.frame_index = $urandom;
		if (narrow) begin
			v.vertex_x = 16'($signed($urandom_range(0, 1024)) - 512);
			v.vertex_y = 16'($signed($urandom_range(0, 1024)) - 512);
			v.vertex_z = 16'($signed($urandom_range(0, 1024)) - 512);
		end
		return v;
	endfunction

	task automatic run_random(int n, bit gaps);
		for (int i = 0; i < n; i++)
			send(rand_vertex($urandom_range(0, 2) != 0), gaps);
		end_burst();
	endtask

	initial begin
		vertex_req_t v;
		sb = new();
		cycles = 0;
		sent = 0;
		rot_step = 1024;
		view_dist = 768;
		proj_scale = 32;
		scr_w = 80;
		scr_h = 40;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset values, extremes of the fields
		v = '{16'sh0100, 16'sh0100, 16'sh0000, 16'd0};    send(v, 0);
		v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff}; send(v, 0);
		v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'h0000}; send(v, 0);
		v = '{16'sh0000, 16'sh0000, 16'shfd00, 16'd0};    send(v, 0); // depth zero
		v = '{16'sh0000, 16'sh0000, 16'shfc00, 16'd0};    send(v, 0); // depth negative
		v = '{16'sh7fff, 16'sh8000, 16'shfd01, 16'd0};    send(v, 0); // saturation
		for (int q = 0; q < 8; q++) begin
			v = '{16'sh0200, 16'shff00, 16'sh0100, 16'(q * 8)};
			send(v, 0);
		end
		end_burst();
		drain();

		// zero screen, large scale
		set_config(16'hffff, 0, 16'hffff, 0, 0);
		v = '{16'sh0100, 16'sh0100, 16'sh0100, 16'd1};    send(v, 0);
		v = '{16'sh0001, 16'shffff, 16'sh0001, 16'd3};    send(v, 0);
		end_burst();
		run_random(150, 1);
		drain();

		set_config(0, 15'h7fff, 0, 12'hfff, 12'hfff);
		v = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'hffff}; send(v, 0);
		end_burst();
		run_random(150, 1);
		drain();

		set_config(1, 1, 1, 1, 1);
		run_random(150, 1);
		drain();

		for (int p = 0; p < 3; p++) begin
			set_config($urandom_range(0, 65535), $urandom_range(0, 32767),
				$urandom_range(0, 300), $urandom_range(1, 4095), $urandom_range(1, 4095));
			run_random(150, 1);
			drain();
		end

		set_config(1024, 768, 32, 80, 40);
		run_random(100, 0);
		drain();

		$display("Covered %0d vertex requests over 8 register settings; %0d results checked.",
			sent, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
